// ----- sv/pose_frame_parser_macros.svh -----
// Assertion helpers for the pose frame parser.
`ifndef POSE_FRAME_PARSER_MACROS_SVH
`define POSE_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pose_frame_parser: implication check failed");

// Next-cycle implication.
`define PFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pose_frame_parser: next-cycle check failed");

`endif

// ----- sv/pfp_pkg.sv -----
package pfp_pkg;

  localparam logic [7:0]  HDR_A     = 8'hAE;
  localparam logic [7:0]  HDR_B     = 8'hEA;
  localparam logic [7:0]  TAIL_A    = 8'hEF;
  localparam logic [7:0]  TAIL_B    = 8'hFE;
  localparam logic [15:0] WORD_BIAS = 16'd10000;

  localparam int unsigned NUM_WORDS   = 6;
  localparam int unsigned NUM_PAYLOAD = 2 * NUM_WORDS;
  localparam int unsigned STORE_DEPTH = NUM_PAYLOAD + 1;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned SUM_W       = 12;

  // Reciprocal of ten scaled by 2^19; exact for every 16-bit magnitude.
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_HDR_B   = 5'b00010,
    ST_PAYLOAD = 5'b00100,
    ST_TAIL_A  = 5'b01000,
    ST_TAIL_B  = 5'b10000
  } pfp_state_e;

  // One complete frame as handed from the parser to the decoder.
  typedef struct packed {
    logic [NUM_WORDS-1:0][15:0] words;
    logic [7:0]                 chk;
    logic [SUM_W-1:0]           sum;
  } frame_t;

  // Signed division by ten, truncated toward zero.
  function automatic logic signed [15:0] div10(input logic signed [15:0] v);
    logic        neg;
    logic [16:0] mag;
    logic [32:0] prod;
    logic [15:0] quo;
    neg  = v[15];
    mag  = neg ? (17'd0 - {v[15], v}) : {1'b0, v};
    prod = mag * {1'b0, RECIP_10};
    quo  = {2'b00, prod[RECIP_SHIFT+13:RECIP_SHIFT]};
    return neg ? $signed(16'd0 - quo) : $signed(quo);
  endfunction

endpackage

// ----- sv/pose_frame_parser.sv -----
// One received byte is taken per cycle; the input stalls only while a parsed frame and a
// result both wait downstream.
// After the final tail byte is transferred, the frame register and then the result register
// are loaded before the result is valid. Frames are at least 17 bytes apart.
// Reset (rst_ni low, asynchronous) returns the parser to idle, empties both stages and clears
// the running sum, the fresh and link flags and the update counter.
`include "pose_frame_parser_macros.svh"

module pose_frame_parser
  import pfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               checksum_ok_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic signed [15:0] vel_x_o,
  output logic signed [15:0] vel_y_o,
  output logic signed [15:0] vel_z_o,
  output logic               fresh_o,
  output logic               link_up_o,
  output logic [15:0]        update_count_o
);

  logic   frm_valid;
  logic   frm_ready;
  frame_t frm;

  pfp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .frm_valid_o(frm_valid),
    .frm_ready_i(frm_ready),
    .frm_o      (frm)
  );

  pfp_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frm_valid_i   (frm_valid),
    .frm_ready_o   (frm_ready),
    .frm_i         (frm),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .checksum_ok_o (checksum_ok_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .vel_x_o       (vel_x_o),
    .vel_y_o       (vel_y_o),
    .vel_z_o       (vel_z_o),
    .fresh_o       (fresh_o),
    .link_up_o     (link_up_o),
    .update_count_o(update_count_o)
  );

  // The input may only stall behind a pending frame.
  `PFP_ASSERT_IMP(a_stall_needs_frame, !in_ready_o, frm_valid)
  // A frame handed to the decoder always shows up as a result.
  `PFP_ASSERT_NEXT(a_frame_gives_result, frm_valid && frm_ready, out_valid_o)
  // A changed payload sum can never leave the link down.
  `PFP_ASSERT_IMP(a_fresh_implies_link, out_valid_o && fresh_o, link_up_o)

endmodule

// ----- sv/pfp_parser.sv -----
module pfp_parser
  import pfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       frm_valid_o,
  input  logic       frm_ready_i,
  output frame_t     frm_o
);

  pfp_state_e       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [7:0]       store_q [STORE_DEPTH];
  logic             frm_valid_q;
  frame_t           frm_q;
  logic             accept;
  logic             store_we;
  logic             frame_done;

  // A new byte is refused only while a finished frame waits and cannot move on.
  assign in_ready_o = !frm_valid_q || frm_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    store_we   = 1'b0;
    frame_done = 1'b0;
    if (accept) begin
      case (state_q)
        ST_IDLE: begin
          state_d = (rx_byte_i == HDR_A) ? ST_HDR_B : ST_IDLE;
        end
        ST_HDR_B: begin
          if (rx_byte_i == HDR_B) begin
            state_d = ST_PAYLOAD;
            idx_d   = '0;
            sum_d   = '0;
          end else begin
            state_d = ST_IDLE;
          end
        end
        ST_PAYLOAD: begin
          store_we = 1'b1;
          if (idx_q == IDX_W'(NUM_PAYLOAD)) begin
            state_d = ST_TAIL_A;
          end else begin
            sum_d = sum_q + {{(SUM_W-8){1'b0}}, rx_byte_i};
            idx_d = idx_q + 1'b1;
          end
        end
        ST_TAIL_A: begin
          state_d = (rx_byte_i == TAIL_A) ? ST_TAIL_B : ST_IDLE;
        end
        ST_TAIL_B: begin
          state_d    = ST_IDLE;
          frame_done = (rx_byte_i == TAIL_B);
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      sum_q       <= '0;
      frm_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      if (frame_done) begin
        frm_valid_q <= 1'b1;
      end else if (frm_ready_i) begin
        frm_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[idx_q] <= rx_byte_i;
    end
  end

  // The payload is copied out so the next frame can be parsed while this one waits.
  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        frm_q.words[w] <= {store_q[2*w], store_q[2*w+1]};
      end
      frm_q.chk <= store_q[NUM_PAYLOAD];
      frm_q.sum <= sum_q;
    end
  end

  assign frm_valid_o = frm_valid_q;
  assign frm_o       = frm_q;

endmodule

// ----- sv/pfp_decode.sv -----
module pfp_decode
  import pfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               frm_valid_i,
  output logic               frm_ready_o,
  input  frame_t             frm_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               checksum_ok_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic signed [15:0] vel_x_o,
  output logic signed [15:0] vel_y_o,
  output logic signed [15:0] vel_z_o,
  output logic               fresh_o,
  output logic               link_up_o,
  output logic [15:0]        update_count_o
);

  logic signed [15:0] dec [NUM_WORDS];
  logic               ok;
  logic               load;
  logic [SUM_W-1:0]   cur_sum_q;
  logic               fresh_q, fresh_d;
  logic               link_q, link_d;
  logic [15:0]        cnt_q, cnt_d;
  logic               out_valid_q;

  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      dec[w] = $signed(frm_i.words[w] - WORD_BIAS);
    end
  end

  assign ok   = (frm_i.sum[7:0] == frm_i.chk);
  assign load = frm_valid_i && (!out_valid_q || out_ready_i);

  assign frm_ready_o = !out_valid_q || out_ready_i;

  // Flags and the counter only move on a good checksum.
  always_comb begin
    fresh_d = fresh_q;
    link_d  = link_q;
    cnt_d   = cnt_q;
    if (ok) begin
      fresh_d = (frm_i.sum != cur_sum_q);
      link_d  = !((frm_i.sum == '0) && (cur_sum_q == '0));
      cnt_d   = cnt_q + {15'd0, fresh_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cur_sum_q   <= '0;
      fresh_q     <= 1'b0;
      link_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        cur_sum_q   <= frm_i.sum;
        fresh_q     <= fresh_d;
        link_q      <= link_d;
        cnt_q       <= cnt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      checksum_ok_o  <= ok;
      pos_x_o        <= dec[0];
      pos_y_o        <= dec[1];
      pos_z_o        <= dec[2];
      vel_x_o        <= ok ? div10(dec[5]) : dec[3];
      vel_y_o        <= ok ? div10(dec[4]) : dec[4];
      vel_z_o        <= ok ? div10(dec[3]) : dec[5];
      fresh_o        <= fresh_d;
      link_up_o      <= link_d;
      update_count_o <= cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam logic [0:3][15:0] EDGE_WORDS = {16'hA70F, 16'hA710, 16'h0000, 16'hFFFF};

  typedef struct packed {
    logic               ok;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic               fresh;
    logic               link;
    logic [15:0]        cnt;
  } pose_t;

  typedef enum logic [2:0] {
    ROW_FRAME,
    ROW_NOISE,
    ROW_HDR_BREAK,
    ROW_TAILA_BREAK,
    ROW_TAILB_BREAK
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [0:5][15:0] words;
    logic             bad_chk;
    logic             typed;
    pose_t            want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               checksum_ok_o;
  logic signed [15:0] pos_x_o;
  logic signed [15:0] pos_y_o;
  logic signed [15:0] pos_z_o;
  logic signed [15:0] vel_x_o;
  logic signed [15:0] vel_y_o;
  logic signed [15:0] vel_z_o;
  logic               fresh_o;
  logic               link_up_o;
  logic [15:0]        update_count_o;

  pose_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .checksum_ok_o (checksum_ok_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .vel_x_o       (vel_x_o),
    .vel_y_o       (vel_y_o),
    .vel_z_o       (vel_z_o),
    .fresh_o       (fresh_o),
    .link_up_o     (link_up_o),
    .update_count_o(update_count_o)
  );

  always #1 clk_i = ~clk_i;

  // Parser shadow state, advanced on every byte transfer.
  int unsigned frame_pos = 0;
  logic [7:0]  frame_bytes [13];
  logic [11:0] sum_now = '0;
  logic [11:0] sum_last = '0;
  logic        fresh_now = 1'b0;
  logic        link_now = 1'b0;
  logic [15:0] good_count = '0;

  pose_t pending_poses [$];
  logic [0:5][15:0] last_words = '0;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  row_t directed_rows [14] = '{
    // All-zero payload right after reset: both sums zero, so no fresh and no link.
    '{kind: ROW_FRAME, words: '0, bad_chk: 1'b0, typed: 1'b1,
      want: '{ok: 1'b1, px: -10000, py: -10000, pz: -10000, vx: -1000, vy: -1000,
              vz: -1000, fresh: 1'b0, link: 1'b0, cnt: 16'd0}},
    '{kind: ROW_FRAME, words: '0, bad_chk: 1'b1, typed: 1'b1,
      want: '{ok: 1'b0, px: -10000, py: -10000, pz: -10000, vx: -10000, vy: -10000,
              vz: -10000, fresh: 1'b0, link: 1'b0, cnt: 16'd0}},
    '{kind: ROW_FRAME, words: '1, bad_chk: 1'b0, typed: 1'b1,
      want: '{ok: 1'b1, px: -10001, py: -10001, pz: -10001, vx: -1000, vy: -1000,
              vz: -1000, fresh: 1'b1, link: 1'b1, cnt: 16'd1}},
    '{kind: ROW_FRAME, words: '1, bad_chk: 1'b0, typed: 1'b1,
      want: '{ok: 1'b1, px: -10001, py: -10001, pz: -10001, vx: -1000, vy: -1000,
              vz: -1000, fresh: 1'b0, link: 1'b1, cnt: 16'd1}},
    '{kind: ROW_FRAME, words: '1, bad_chk: 1'b1, typed: 1'b1,
      want: '{ok: 1'b0, px: -10001, py: -10001, pz: -10001, vx: -10001, vy: -10001,
              vz: -10001, fresh: 1'b0, link: 1'b1, cnt: 16'd1}},
    '{kind: ROW_HDR_BREAK,
      words: {16'h0102, 16'h0304, 16'h0506, 16'h0708, 16'h090A, 16'h0B0C},
      bad_chk: 1'b0, typed: 1'b0, want: '0},
    '{kind: ROW_NOISE,
      words: {16'h00FF, 16'hEAEF, 16'hFE55, 16'hAA7F, 16'h8001, 16'h1357},
      bad_chk: 1'b0, typed: 1'b0, want: '0},
    '{kind: ROW_TAILA_BREAK,
      words: {16'h2710, 16'hA70F, 16'hA710, 16'hA70F, 16'hA710, 16'h2711},
      bad_chk: 1'b0, typed: 1'b0, want: '0},
    '{kind: ROW_TAILB_BREAK,
      words: {16'h2710, 16'hA70F, 16'hA710, 16'hA70F, 16'hA710, 16'h2711},
      bad_chk: 1'b0, typed: 1'b0, want: '0},
    '{kind: ROW_FRAME,
      words: {16'h2710, 16'hA70F, 16'hA710, 16'hA70F, 16'hA710, 16'h2711},
      bad_chk: 1'b0, typed: 1'b0, want: '0},
    '{kind: ROW_FRAME,
      words: {16'h2710, 16'hA70F, 16'hA710, 16'hA70F, 16'hA710, 16'h2711},
      bad_chk: 1'b1, typed: 1'b0, want: '0},
    '{kind: ROW_FRAME,
      words: {16'h5A5A, 16'hA5A5, 16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3},
      bad_chk: 1'b0, typed: 1'b0, want: '0},
    '{kind: ROW_FRAME, words: '0, bad_chk: 1'b0, typed: 1'b0, want: '0},
    '{kind: ROW_FRAME, words: '0, bad_chk: 1'b0, typed: 1'b0, want: '0}
  };

  function automatic logic [7:0] low_sum(input logic [0:5][15:0] w);
    logic [7:0] s;
    s = '0;
    for (int k = 0; k < 6; k++) s += w[k][15:8] + w[k][7:0];
    return s;
  endfunction

  // Advances the shadow parser by one byte; returns 1 when a frame completes.
  function automatic bit track_byte(input logic [7:0] b, output pose_t r);
    logic [11:0]        s;
    logic signed [15:0] d [6];
    logic               ok;
    r = '0;
    case (frame_pos)
      0: frame_pos = (b == HDR_A) ? 1 : 0;
      1: frame_pos = (b == HDR_B) ? 2 : 0;
      15: frame_pos = (b == TAIL_A) ? 16 : 0;
      16: begin
        frame_pos = 0;
        if (b == TAIL_B) begin
          s = '0;
          for (int i = 0; i < 12; i++) s += frame_bytes[i];
          for (int k = 0; k < 6; k++) d[k] = {frame_bytes[2*k], frame_bytes[2*k+1]} - WORD_BIAS;
          sum_last = sum_now;
          sum_now  = s;
          ok = (s[7:0] == frame_bytes[12]);
          r.ok = ok;
          r.px = d[0];
          r.py = d[1];
          r.pz = d[2];
          if (ok) begin
            // Velocity axes are swapped x<->z and scaled down, truncating toward zero.
            r.vx = 16'(int'(d[5]) / 10);
            r.vy = 16'(int'(d[4]) / 10);
            r.vz = 16'(int'(d[3]) / 10);
            fresh_now = (sum_now != sum_last);
            if (fresh_now) good_count = good_count + 16'd1;
            link_now = !(sum_now == '0 && sum_last == '0);
          end else begin
            r.vx = d[3];
            r.vy = d[4];
            r.vz = d[5];
          end
          r.fresh = fresh_now;
          r.link  = link_now;
          r.cnt   = good_count;
          return 1'b1;
        end
      end
      default: begin
        frame_bytes[frame_pos - 2] = b;
        frame_pos = frame_pos + 1;
      end
    endcase
    return 1'b0;
  endfunction

  // Valid is lowered only when a gap is taken, so it never sees two updates in one step.
  task automatic send_byte(input logic [7:0] b, input bit typed, input pose_t want);
    pose_t got;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    if (track_byte(b, got)) pending_poses.push_back(typed ? want : got);
  endtask

  task automatic send_frame(input row_kind_e kind, input logic [0:5][15:0] w,
                            input logic [7:0] chk, input bit typed, input pose_t want);
    logic [7:0] seq [$];
    if (kind == ROW_HDR_BREAK) seq = '{HDR_A, HDR_A, HDR_B};
    else if (kind != ROW_NOISE) seq = '{HDR_A, HDR_B};
    for (int k = 0; k < 6; k++) begin
      seq.push_back(w[k][15:8]);
      seq.push_back(w[k][7:0]);
    end
    if (kind != ROW_NOISE) begin
      seq.push_back(chk);
      // A header byte in a tail slot must be dropped, not taken as a new frame start.
      case (kind)
        ROW_TAILA_BREAK: seq.push_back(HDR_A);
        ROW_TAILB_BREAK: begin
          seq.push_back(TAIL_A);
          seq.push_back(HDR_A);
        end
        default: begin
          seq.push_back(TAIL_A);
          seq.push_back(TAIL_B);
        end
      endcase
    end
    foreach (seq[i]) send_byte(seq[i], typed, want);
  endtask

  task automatic random_frame();
    logic [0:5][15:0] w;
    logic [7:0]       chk;
    row_kind_e        kind;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 10) w = last_words;
    else if (pick < 16) w = '0;
    else begin
      for (int k = 0; k < 6; k++) begin
        case ($urandom_range(3))
          0: w[k] = 16'd9980 + 16'($urandom_range(40));
          1: w[k] = EDGE_WORDS[$urandom_range(3)];
          default: w[k] = 16'($urandom);
        endcase
      end
    end
    last_words = w;
    chk = low_sum(w);
    if ($urandom_range(99) < 25) chk ^= 8'(1 << $urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 5) kind = ROW_HDR_BREAK;
    else if (pick < 10) kind = ROW_TAILA_BREAK;
    else if (pick < 15) kind = ROW_TAILB_BREAK;
    else if (pick < 20) kind = ROW_NOISE;
    else kind = ROW_FRAME;
    send_frame(kind, w, chk, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_poses.size() != 0);
  endtask

  function automatic void compare_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_pose();
    pose_t e;
    if (pending_poses.size() == 0) begin
      $display("%0t: result transfer with nothing expected", $time);
      mismatches++;
    end else begin
      e = pending_poses.pop_front();
      compare_field("checksum_ok", e.ok, checksum_ok_o);
      compare_field("pos_x", e.px, pos_x_o);
      compare_field("pos_y", e.py, pos_y_o);
      compare_field("pos_z", e.pz, pos_z_o);
      compare_field("vel_x", e.vx, vel_x_o);
      compare_field("vel_y", e.vy, vel_y_o);
      compare_field("vel_z", e.vz, vel_z_o);
      compare_field("fresh", e.fresh, fresh_o);
      compare_field("link_up", e.link, link_up_o);
      compare_field("update_count", e.cnt, update_count_o);
    end
  endtask

  initial begin : receiver
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_pose();
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("pose_frame_parser: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    gap_pct   = 15;
    stall_pct = 57;
    foreach (directed_rows[i]) begin
      send_frame(directed_rows[i].kind, directed_rows[i].words,
                 low_sum(directed_rows[i].words) ^ {7'd0, directed_rows[i].bad_chk},
                 directed_rows[i].typed, directed_rows[i].want);
    end
    while (bytes_sent < 330) random_frame();
    wait_drained();

    gap_pct   = 57;
    stall_pct = 15;
    while (bytes_sent < 540) random_frame();
    wait_drained();

    // Full rate, with one long receiver hold so the block backs up into its input.
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    while (bytes_sent < 750) random_frame();
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("pose_frame_parser: match");
    end else begin
      $display("pose_frame_parser: mismatch");
    end
    $finish;
  end

endmodule
